/* design/microstep_phase_sequencer_core_macros.svh */
// Assertion macros for the microstep phase sequencer checker.
// Included by the checker file only; no other dependencies.
`ifndef MICROSTEP_PHASE_SEQUENCER_CORE_MACROS_SVH
`define MICROSTEP_PHASE_SEQUENCER_CORE_MACROS_SVH

// Concurrent assertion, disabled while reset is asserted.
`define MSPS_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Concurrent assertion that also holds during reset.
`define MSPS_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) \
    else $error(msg);

`endif

/* design/msps_pkg.sv */
// Package for the microstep phase sequencer: constants, register codes
// and the elaboration-time sine ratio table generator. No dependencies.
package msps_pkg;

  localparam int unsigned MAX_STEP_LOG2_DEF = 8;
  localparam int unsigned MIN_STEP_LOG2     = 3;
  localparam int unsigned STEP_SIZE_RESET   = 4;

  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned STEP_CFG_W = 4;
  localparam int unsigned OFFSET_W   = 16;
  localparam int unsigned RATIO_W    = 17;
  localparam int unsigned PWM_W      = 8;
  localparam int unsigned POS_W      = 10;

  localparam logic [31:0] PI8_Q32 = 32'd1686629713;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_STEP_SIZE_LOG2 = 1'b0,
    CFG_DUTY_OFFSET    = 1'b1
  } cfg_idx_e;

  // sin(pi/8 * t / 2^m) in Q0.32, Taylor series to the ninth power
  function automatic logic [63:0] sine_q32(input int unsigned t, input int unsigned m);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] s;
    x    = (64'(PI8_Q32) * 64'(t)) >> m;
    x2   = (x * x) >> 32;
    term = x;
    s    = x;
    term = ((term * x2) >> 32) / 64'd6;
    s    = s - term;
    term = ((term * x2) >> 32) / 64'd20;
    s    = s + term;
    term = ((term * x2) >> 32) / 64'd42;
    s    = s - term;
    term = ((term * x2) >> 32) / 64'd72;
    s    = s + term;
    return s;
  endfunction

  // sin(pi/8) in Q0.32, the same for every table size
  localparam logic [63:0] SINE_TOP = sine_q32(1, 0);

  // Q1.16 ratio sin(pi/8*t/T) / sin(pi/8), rounded; constant use only
  function automatic logic [RATIO_W-1:0] ratio_rom(input int unsigned t,
                                                   input int unsigned m);
    logic [63:0] s;
    s = sine_q32(t, m);
    return RATIO_W'(((s << 16) + (SINE_TOP >> 1)) / SINE_TOP);
  endfunction

endpackage

/* design/msps_step_if.sv */
// Step tick channel: valid/ready handshake carrying the direction bit.
// No dependencies.
interface msps_step_if;
  logic valid;
  logic ready;
  logic direction;

  modport source (output valid, output direction, input ready);
  modport sink   (input valid, input direction, output ready);
endinterface

/* design/msps_result_if.sv */
// Result channel: valid/ready handshake carrying both winding drives and position.
// Depends on msps_pkg for field widths.
interface msps_result_if;
  logic                          valid;
  logic                          ready;
  logic [msps_pkg::PWM_W-1:0]    winding_a_pwm;
  logic                          winding_a_phase;
  logic [msps_pkg::PWM_W-1:0]    winding_b_pwm;
  logic                          winding_b_phase;
  logic [msps_pkg::POS_W-1:0]    position;

  modport source (output valid, output winding_a_pwm, output winding_a_phase,
                  output winding_b_pwm, output winding_b_phase, output position,
                  input ready);
  modport sink   (input valid, input winding_a_pwm, input winding_a_phase,
                  input winding_b_pwm, input winding_b_phase, input position,
                  output ready);
endinterface

/* design/msps_duty.sv */
// One winding's duty: sine ratio table lookup, offset blend and 255x scale.
// Depends on msps_pkg for the table generator and widths.
module msps_duty #(
  parameter int unsigned MAX_STEP_LOG2 = msps_pkg::MAX_STEP_LOG2_DEF
) (
  input  logic [MAX_STEP_LOG2:0]           rom_idx_i,
  input  logic [msps_pkg::OFFSET_W-1:0]    offset_i,
  output logic [msps_pkg::PWM_W-1:0]       pwm_o
);

  localparam int unsigned TAB_DEPTH = 1 << MAX_STEP_LOG2;
  localparam int unsigned RW        = msps_pkg::RATIO_W;
  localparam int unsigned OW        = msps_pkg::OFFSET_W;
  localparam logic [RW-1:0] ONE_Q16 = RW'(1) << OW;

  logic [RW-1:0] tab [TAB_DEPTH];

  for (genvar gi = 0; gi < TAB_DEPTH; gi++) begin : g_tab
    localparam logic [RW-1:0] RomVal = msps_pkg::ratio_rom(gi, MAX_STEP_LOG2);
    assign tab[gi] = RomVal;
  end

  logic [RW-1:0]        ratio;
  logic [RW-1:0]        inv_off;
  logic [2*RW-1:0]      prod;
  logic [2*OW:0]        blend;
  logic [2*OW+8:0]      scaled;

  // entry T itself is exactly 1.0
  assign ratio   = rom_idx_i[MAX_STEP_LOG2] ? ONE_Q16
                                            : tab[rom_idx_i[MAX_STEP_LOG2-1:0]];
  assign inv_off = ONE_Q16 - RW'(offset_i);
  assign prod    = inv_off * ratio;
  assign blend   = {1'b0, offset_i, OW'(0)} + (2*OW+1)'(prod);
  assign scaled  = {blend, 8'h00} - (2*OW+9)'(blend);
  assign pwm_o   = scaled[2*OW+7:2*OW];

endmodule

/* design/microstep_phase_sequencer_core.sv */
// Two-winding stepper microstep sequencer, top level.
// Depends on msps_pkg, msps_step_if, msps_result_if and msps_duty.
//
// Usage:
//   step_i   : one beat per step tick; direction 1 counts forward, 0 reverse.
//   result_o : one beat per tick with PWM duty and phase for windings A and B
//              and the position the outputs were taken from.
//   cfg_*    : register write port; index 0 step_size_log2 (clamped to
//              3..MAX_STEP_LOG2), index 1 duty_offset. Changing the effective
//              step size clears the position. Write only while idle.
// Timing: the result register captures the outputs at the edge that accepts
//   the tick. Throughput: one tick per cycle while result_o is not stalled;
//   position update, index calculation and both table lookups are combinational
//   between the position register and the result register.
// Stall: the result register holds while result_o.ready is low; step_i.ready
//   stays high as long as the result register is empty or being drained.
// Reset: position 0, step size 4, offset 0, no result pending.
module microstep_phase_sequencer_core #(
  parameter int unsigned MAX_STEP_LOG2 = msps_pkg::MAX_STEP_LOG2_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [msps_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [msps_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  msps_step_if.sink                         step_i,
  msps_result_if.source                     result_o
);

  localparam int unsigned CNT_W = MAX_STEP_LOG2 + 2;
  localparam int unsigned J_W   = MAX_STEP_LOG2 + 1;
  localparam int unsigned K_W   = $clog2(MAX_STEP_LOG2 + 1);
  localparam int unsigned POS_W = msps_pkg::POS_W;
  localparam int unsigned PWM_W = msps_pkg::PWM_W;
  localparam int unsigned OFF_W = msps_pkg::OFFSET_W;
  localparam int unsigned K_RESET_I =
    (msps_pkg::STEP_SIZE_RESET < msps_pkg::MIN_STEP_LOG2) ? msps_pkg::MIN_STEP_LOG2 :
    (msps_pkg::STEP_SIZE_RESET > MAX_STEP_LOG2) ? MAX_STEP_LOG2 :
    msps_pkg::STEP_SIZE_RESET;
  localparam logic [K_W-1:0] K_RESET = K_W'(K_RESET_I);
  localparam logic [K_W-1:0] K_MIN   = K_W'(msps_pkg::MIN_STEP_LOG2);
  localparam logic [K_W-1:0] K_MAX   = K_W'(MAX_STEP_LOG2);

  logic [K_W-1:0]   k_q;
  logic [OFF_W-1:0] offset_q;
  logic [CNT_W-1:0] pos_q, pos_d;

  logic             step_acc;
  logic             res_valid_q, res_valid_d;
  logic [PWM_W-1:0] a_pwm_q, b_pwm_q, a_pwm, b_pwm;
  logic             a_ph_q, b_ph_q, a_ph, b_ph;
  logic [POS_W-1:0] pos_out_q;

  // config decode
  logic [msps_pkg::STEP_CFG_W-1:0] raw_k;
  logic [K_W-1:0]                  k_new;
  logic                            k_change;

  assign raw_k = cfg_data_i[msps_pkg::STEP_CFG_W-1:0];

  always_comb begin
    if (int'(raw_k) < int'(msps_pkg::MIN_STEP_LOG2)) begin
      k_new = K_MIN;
    end else if (int'(raw_k) > int'(MAX_STEP_LOG2)) begin
      k_new = K_MAX;
    end else begin
      k_new = K_W'(raw_k);
    end
  end

  assign k_change = cfg_we_i &&
                    (msps_pkg::cfg_idx_e'(cfg_idx_i) == msps_pkg::CFG_STEP_SIZE_LOG2) &&
                    (k_new != k_q);

  // index math
  logic [CNT_W-1:0] n, c, shifted;
  logic [CNT_W:0]   span, pos_ext;
  logic             q;
  logic             fwd;
  logic [CNT_W-1:0] j_up, j_dn, j_c, j_nc;
  logic [J_W-1:0]   ja, jb, ta, tb;
  logic [K_W-1:0]   t_shift;

  assign fwd     = step_i.direction;
  assign n       = CNT_W'(1) << k_q;
  assign span    = (CNT_W + 1)'(n) << 2;
  assign c       = pos_q & (n - CNT_W'(1));
  assign shifted = pos_q >> k_q;
  assign q       = shifted[0];
  assign b_ph    = shifted[1];
  assign a_ph    = b_ph ? q : ~q;
  assign j_up    = c + CNT_W'(1);
  assign j_dn    = n - CNT_W'(1) - c;
  assign j_c     = c;
  assign j_nc    = n - c;

  always_comb begin
    if (fwd) begin
      ja = J_W'(q ? j_up : j_dn);
      jb = J_W'(q ? j_dn : j_up);
    end else begin
      ja = J_W'(q ? j_c : j_nc);
      jb = J_W'(q ? j_nc : j_c);
    end
  end

  assign t_shift = K_MAX - k_q;
  assign ta      = ja << t_shift;
  assign tb      = jb << t_shift;

  msps_duty #(.MAX_STEP_LOG2(MAX_STEP_LOG2)) u_duty_a (
    .rom_idx_i (ta),
    .offset_i  (offset_q),
    .pwm_o     (a_pwm)
  );

  msps_duty #(.MAX_STEP_LOG2(MAX_STEP_LOG2)) u_duty_b (
    .rom_idx_i (tb),
    .offset_i  (offset_q),
    .pwm_o     (b_pwm)
  );

  // next position, wrapping both ways; a step size change clears it
  assign pos_ext = (CNT_W + 1)'(pos_q);

  always_comb begin
    pos_d = pos_q;
    if (step_acc) begin
      if (fwd) begin
        pos_d = (pos_ext + 1'b1 == span) ? '0 : CNT_W'(pos_ext + 1'b1);
      end else begin
        pos_d = (pos_q == '0) ? CNT_W'(span - 1'b1) : pos_q - CNT_W'(1);
      end
    end
    if (k_change) begin
      pos_d = '0;
    end
  end

  logic [POS_W+CNT_W-1:0] pos_wide;
  assign pos_wide = {POS_W'(0), pos_q};

  // handshake
  assign step_acc     = step_i.valid & step_i.ready;
  assign step_i.ready = ~res_valid_q | result_o.ready;
  assign res_valid_d  = step_acc | (res_valid_q & ~result_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q         <= K_RESET;
      offset_q    <= '0;
      pos_q       <= '0;
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= res_valid_d;
      pos_q       <= pos_d;
      if (cfg_we_i) begin
        case (msps_pkg::cfg_idx_e'(cfg_idx_i))
          msps_pkg::CFG_STEP_SIZE_LOG2: begin
            k_q <= k_new;
          end
          msps_pkg::CFG_DUTY_OFFSET: begin
            offset_q <= cfg_data_i[OFF_W-1:0];
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_acc) begin
      a_pwm_q   <= a_pwm;
      a_ph_q    <= a_ph;
      b_pwm_q   <= b_pwm;
      b_ph_q    <= b_ph;
      pos_out_q <= pos_wide[POS_W-1:0];
    end
  end

  assign result_o.valid           = res_valid_q;
  assign result_o.winding_a_pwm   = a_pwm_q;
  assign result_o.winding_a_phase = a_ph_q;
  assign result_o.winding_b_pwm   = b_pwm_q;
  assign result_o.winding_b_phase = b_ph_q;
  assign result_o.position        = pos_out_q;

endmodule

/* design/msps_checker.sv */
// Port-level checker for the microstep phase sequencer, bound to the top level.
// Depends on msps_pkg and microstep_phase_sequencer_core_macros.svh.
`include "microstep_phase_sequencer_core_macros.svh"

module msps_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          cfg_we_i,
  input logic                          step_valid_i,
  input logic                          step_ready_i,
  input logic                          step_direction_i,
  input logic                          res_valid_i,
  input logic                          res_ready_i,
  input logic [msps_pkg::POS_W-1:0]    res_position_i
);

  logic step_acc;
  assign step_acc = step_valid_i & step_ready_i;

  `MSPS_ASSERT(a_res_valid_hold, clk_i, rst_ni, res_valid_i && !res_ready_i |=> res_valid_i, "result beat dropped while stalled")
  `MSPS_ASSERT(a_res_pos_stable, clk_i, rst_ni, res_valid_i && !res_ready_i |=> $stable(res_position_i), "stalled result changed")
  `MSPS_ASSERT(a_step_gives_res, clk_i, rst_ni, step_acc |=> res_valid_i, "accepted step gave no result")
  `MSPS_ASSERT_ALWAYS(a_no_overwrite, clk_i, step_ready_i |-> (!res_valid_i || res_ready_i), "step taken over a pending result")
  `MSPS_ASSERT(a_fwd_advance, clk_i, rst_ni, (step_acc && step_direction_i && !cfg_we_i) ##1 (step_acc && step_direction_i && !cfg_we_i) |=> (res_position_i == $past(res_position_i) + 10'd1) || (res_position_i == 10'd0), "forward step did not advance position")

endmodule

bind microstep_phase_sequencer_core msps_checker u_msps_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .cfg_we_i         (cfg_we_i),
  .step_valid_i     (step_i.valid),
  .step_ready_i     (step_i.ready),
  .step_direction_i (step_i.direction),
  .res_valid_i      (result_o.valid),
  .res_ready_i      (result_o.ready),
  .res_position_i   (result_o.position)
);

/* sim/testbench.sv */
// Self-checking testbench for microstep_phase_sequencer_core: directed table, then random ticks
// checked against a shadow model of the counter, phase logic and sine duty table.
// Depends on msps_pkg, msps_step_if, msps_result_if and the RTL top level.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import msps_pkg::*;

  localparam int unsigned MAX_K     = MAX_STEP_LOG2_DEF;
  localparam int unsigned RAND_TICKS = 850;
  localparam int unsigned HOLD_BEAT  = 400;
  localparam int unsigned HOLD_CYC   = 60;

  typedef struct packed {
    logic [PWM_W-1:0] a_pwm;
    logic             a_ph;
    logic [PWM_W-1:0] b_pwm;
    logic             b_ph;
    logic [POS_W-1:0] pos;
  } drive_t;

  typedef struct packed {
    logic                  wr;
    cfg_idx_e              idx;
    logic [CFG_DATA_W-1:0] data;
    logic                  dir;
    logic                  typed;
    drive_t                exp;
  } dir_row_t;

  localparam int unsigned NUM_ROWS = 20;
  localparam drive_t NO_EXP = '0;
  localparam dir_row_t DIR_TAB [NUM_ROWS] = '{
    '{1'b0, CFG_STEP_SIZE_LOG2, 16'h0000, 1'b0, 1'b1, '{8'd255, 1'b1, 8'd0, 1'b0, 10'd0}},
    '{1'b0, CFG_STEP_SIZE_LOG2, 16'h0000, 1'b1, 1'b1, '{8'd255, 1'b1, 8'd0, 1'b1, 10'd63}},
    '{1'b0, CFG_STEP_SIZE_LOG2, 16'h0000, 1'b1, 1'b0, NO_EXP},
    '{1'b0, CFG_STEP_SIZE_LOG2, 16'h0000, 1'b1, 1'b0, NO_EXP},
    '{1'b1, CFG_STEP_SIZE_LOG2, 16'h0003, 1'b0, 1'b0, NO_EXP},
    '{1'b0, CFG_STEP_SIZE_LOG2, 16'h0000, 1'b1, 1'b0, NO_EXP},
    '{1'b1, CFG_STEP_SIZE_LOG2, 16'h0008, 1'b1, 1'b0, NO_EXP},
    '{1'b0, CFG_STEP_SIZE_LOG2, 16'h0000, 1'b0, 1'b0, NO_EXP},
    '{1'b1, CFG_DUTY_OFFSET,    16'hFFFF, 1'b0, 1'b1, '{8'd255, 1'b1, 8'd254, 1'b0, 10'd0}},
    '{1'b0, CFG_STEP_SIZE_LOG2, 16'h0000, 1'b1, 1'b1, '{8'd255, 1'b1, 8'd254, 1'b1, 10'd1023}},
    '{1'b1, CFG_STEP_SIZE_LOG2, 16'h0000, 1'b0, 1'b0, NO_EXP},
    '{1'b1, CFG_STEP_SIZE_LOG2, 16'h0002, 1'b1, 1'b0, NO_EXP},
    '{1'b1, CFG_STEP_SIZE_LOG2, 16'h000F, 1'b1, 1'b0, NO_EXP},
    '{1'b1, CFG_STEP_SIZE_LOG2, 16'h0009, 1'b1, 1'b0, NO_EXP},
    '{1'b1, CFG_DUTY_OFFSET,    16'h8000, 1'b0, 1'b0, NO_EXP},
    '{1'b1, CFG_STEP_SIZE_LOG2, 16'hFFF4, 1'b1, 1'b0, NO_EXP},
    '{1'b1, CFG_DUTY_OFFSET,    16'h0000, 1'b1, 1'b0, NO_EXP},
    '{1'b0, CFG_STEP_SIZE_LOG2, 16'h0000, 1'b0, 1'b0, NO_EXP},
    '{1'b1, CFG_DUTY_OFFSET,    16'h0001, 1'b0, 1'b0, NO_EXP},
    '{1'b0, CFG_STEP_SIZE_LOG2, 16'h0000, 1'b1, 1'b0, NO_EXP}
  };

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  msps_step_if   step_bus ();
  msps_result_if res_bus ();

  microstep_phase_sequencer_core uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .step_i     (step_bus),
    .result_o   (res_bus)
  );

  // shadow state
  logic [STEP_CFG_W-1:0] m_step_raw;
  logic [OFFSET_W-1:0]   m_offset;
  int unsigned           m_pos;
  logic [RATIO_W-1:0]    ratio_tab [0:(1 << MAX_K)];

  drive_t      pending_drives [$];
  logic        cur_typed;
  drive_t      cur_expect;
  int unsigned fail_count;
  int unsigned rx_beats;
  logic        tx_fast;
  logic        rx_fast;

  initial clk_i = 1'b0;
  always #2 clk_i = ~clk_i;

  function automatic int unsigned eff_k(input logic [STEP_CFG_W-1:0] raw);
    if (raw < MIN_STEP_LOG2) return MIN_STEP_LOG2;
    if (raw > MAX_K) return MAX_K;
    return raw;
  endfunction

  // Q0.32 sine of pi/8 * t / 2^MAX_K, odd Taylor terms up to x^9
  function automatic logic [63:0] sine_frac(input int unsigned t);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] tm;
    logic [63:0] acc;
    x   = (64'(PI8_Q32) * 64'(t)) >> MAX_K;
    x2  = (x * x) >> 32;
    tm  = x;
    acc = x;
    tm  = ((tm * x2) >> 32) / 64'd6;
    acc = acc - tm;
    tm  = ((tm * x2) >> 32) / 64'd20;
    acc = acc + tm;
    tm  = ((tm * x2) >> 32) / 64'd42;
    acc = acc - tm;
    tm  = ((tm * x2) >> 32) / 64'd72;
    acc = acc + tm;
    return acc;
  endfunction

  function automatic logic [PWM_W-1:0] duty_of(input int unsigned j, input int unsigned k);
    logic [63:0] r;
    logic [63:0] off;
    logic [63:0] v;
    logic [63:0] p;
    r   = 64'(ratio_tab[j << (MAX_K - k)]);
    off = 64'(m_offset);
    v   = (off << 16) + (64'd65536 - off) * r;
    p   = (64'd255 * v) >> 32;
    if (p > 64'd255) p = 64'd255;
    return p[PWM_W-1:0];
  endfunction

  task automatic predict_drive(input logic dir, output drive_t d);
    int unsigned k;
    int unsigned n;
    int unsigned span;
    int unsigned pos;
    int unsigned q;
    int unsigned bph;
    int unsigned c;
    int unsigned ja;
    int unsigned jb;
    k    = eff_k(m_step_raw);
    n    = 1 << k;
    span = n << 2;
    pos  = m_pos % span;
    q    = (pos >> k) & 1;
    bph  = (pos >> (k + 1)) & 1;
    c    = pos & (n - 1);
    if (dir) begin
      ja = q ? (1 + c) : (n - 1 - c);
      jb = q ? (n - 1 - c) : (1 + c);
    end else begin
      ja = q ? c : (n - c);
      jb = q ? (n - c) : c;
    end
    d.a_pwm = duty_of(ja, k);
    d.a_ph  = bph ? q[0] : ~q[0];
    d.b_pwm = duty_of(jb, k);
    d.b_ph  = bph[0];
    d.pos   = pos[POS_W-1:0];
    if (dir) m_pos = (pos + 1 == span) ? 0 : pos + 1;
    else m_pos = (pos == 0) ? span - 1 : pos - 1;
  endtask

  task automatic cfg_write(input cfg_idx_e idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we_i   = 1'b1;
    cfg_idx_i  = idx;
    cfg_data_i = data;
    @(posedge clk_i);
    if (idx == CFG_STEP_SIZE_LOG2) begin
      if (eff_k(data[STEP_CFG_W-1:0]) != eff_k(m_step_raw)) m_pos = 0;
      m_step_raw = data[STEP_CFG_W-1:0];
    end else begin
      m_offset = data[OFFSET_W-1:0];
    end
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  // drop valid and wait until every tick has produced its drive beat
  task automatic drain();
    step_bus.valid = 1'b0;
    while (pending_drives.size() != 0) @(posedge clk_i);
    repeat (2) @(negedge clk_i);
  endtask

  task automatic send_tick(input logic dir);
    int unsigned gap;
    if ($urandom_range(0, 31) == 0) tx_fast = ~tx_fast;
    gap = tx_fast ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      step_bus.valid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    step_bus.valid     = 1'b1;
    step_bus.direction = dir;
    do @(posedge clk_i); while (!step_bus.ready);
    @(negedge clk_i);
  endtask

  always @(posedge clk_i) begin : scoreboard
    drive_t got;
    drive_t want;
    drive_t pred;
    if (rst_ni) begin
      if (res_bus.valid && res_bus.ready) begin
        got = '{res_bus.winding_a_pwm, res_bus.winding_a_phase, res_bus.winding_b_pwm,
                res_bus.winding_b_phase, res_bus.position};
        if (pending_drives.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) $display("unexpected drive beat pos=%0d", got.pos);
        end else begin
          want = pending_drives.pop_front();
          if (got !== want) begin
            fail_count++;
            if (fail_count <= 10)
              $display("drive mismatch: exp a=%0d/%0b b=%0d/%0b pos=%0d, got a=%0d/%0b b=%0d/%0b pos=%0d",
                       want.a_pwm, want.a_ph, want.b_pwm, want.b_ph, want.pos,
                       got.a_pwm, got.a_ph, got.b_pwm, got.b_ph, got.pos);
          end
        end
      end
      if (step_bus.valid && step_bus.ready) begin
        predict_drive(step_bus.direction, pred);
        pending_drives.push_back(cur_typed ? cur_expect : pred);
      end
    end
  end

  // receiver: random back-pressure, one long hold-off to fill the block
  initial begin : receiver
    int unsigned gap;
    res_bus.ready = 1'b0;
    rx_beats      = 0;
    rx_fast       = 1'b0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      if ($urandom_range(0, 31) == 0) rx_fast = ~rx_fast;
      gap = rx_fast ? 0 : $urandom_range(0, 4);
      if (rx_beats == HOLD_BEAT) gap = HOLD_CYC;
      if (gap > 0) begin
        res_bus.ready = 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      res_bus.ready = 1'b1;
      do @(posedge clk_i); while (!res_bus.valid);
      rx_beats++;
      @(negedge clk_i);
    end
  end

  initial begin : watchdog
    #2_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  initial begin : stimulus
    int unsigned sent;
    int unsigned phase_len;
    int unsigned mode;
    int unsigned waited;
    logic        dir;
    rst_ni             = 1'b0;
    cfg_we_i           = 1'b0;
    cfg_idx_i          = CFG_STEP_SIZE_LOG2;
    cfg_data_i         = '0;
    step_bus.valid     = 1'b0;
    step_bus.direction = 1'b0;
    cur_typed          = 1'b0;
    cur_expect         = '0;
    fail_count         = 0;
    tx_fast            = 1'b0;
    m_step_raw         = STEP_CFG_W'(STEP_SIZE_RESET);
    m_offset           = '0;
    m_pos              = 0;
    for (int unsigned t = 0; t <= (1 << MAX_K); t++)
      ratio_tab[t] = RATIO_W'(((sine_frac(t) << 16) + (sine_frac(1 << MAX_K) >> 1)) /
                              sine_frac(1 << MAX_K));
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    for (int unsigned i = 0; i < NUM_ROWS; i++) begin
      if (DIR_TAB[i].wr) begin
        drain();
        cfg_write(DIR_TAB[i].idx, DIR_TAB[i].data);
      end
      cur_typed  = DIR_TAB[i].typed;
      cur_expect = DIR_TAB[i].exp;
      send_tick(DIR_TAB[i].dir);
    end
    cur_typed = 1'b0;

    sent = 0;
    while (sent < RAND_TICKS) begin
      drain();
      case ($urandom_range(0, 3))
        0: cfg_write(CFG_STEP_SIZE_LOG2, CFG_DATA_W'($urandom));
        1: cfg_write(CFG_STEP_SIZE_LOG2, $urandom_range(0, 1) ? 16'd3 : 16'd8);
        2: cfg_write(CFG_STEP_SIZE_LOG2, CFG_DATA_W'($urandom_range(3, 5)));
        default: ;
      endcase
      case ($urandom_range(0, 4))
        0: cfg_write(CFG_DUTY_OFFSET, 16'h0000);
        1: cfg_write(CFG_DUTY_OFFSET, 16'hFFFF);
        2: cfg_write(CFG_DUTY_OFFSET, CFG_DATA_W'($urandom));
        default: ;
      endcase
      phase_len = $urandom_range(10, 80);
      mode      = $urandom_range(0, 2);
      for (int unsigned i = 0; i < phase_len && sent < RAND_TICKS; i++) begin
        case (mode)
          0: dir = $urandom_range(0, 1);
          1: dir = ($urandom_range(0, 7) != 0);
          default: dir = ($urandom_range(0, 7) == 0);
        endcase
        send_tick(dir);
        sent++;
      end
    end

    step_bus.valid = 1'b0;
    waited = 0;
    while (pending_drives.size() != 0 && waited < 1000) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (4) @(posedge clk_i);
    fail_count += pending_drives.size();
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
